>>> design/rebi_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder button interface - shared definitions
// Types, command codes, register indexes and state encodings for the block.
// ----------------------------------------------------------------------------
package rebi_pkg;

    // Command codes of an input item.
    typedef enum logic [1:0] {
        CMD_TICK        = 2'd0,
        CMD_READ_VALUE  = 2'd1,
        CMD_READ_BUTTON = 2'd2
    } t_cmd;

    // Detent arm/confirm states.
    typedef enum logic [1:0] {
        ARM_IDLE  = 2'd0,
        ARM_LEFT  = 2'd1,
        ARM_RIGHT = 2'd2
    } t_arm;

    // Button states as reported to the host.
    typedef enum logic [1:0] {
        BTN_OPEN     = 2'd0,
        BTN_CLICKED  = 2'd1,
        BTN_HELD     = 2'd2,
        BTN_RELEASED = 2'd3
    } t_btn;

    // Configuration port geometry.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LEVEL    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BUTTON_ENABLE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BUTTON_INTERVAL = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_LIMIT      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_ENABLE    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_RATE      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_MAX       = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_DECEL_RATE      = 3'd7;

    // Counter ceiling for the 16-bit saturating counters.
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Saturation bounds of the reported step.
    localparam logic [8:0] STEP_POS_LIMIT = 9'd127;
    localparam logic [8:0] STEP_NEG_LIMIT = 9'd128;

    // Configuration register set.
    typedef struct packed {
        logic        active_level;
        logic        button_enable;
        logic [15:0] button_interval;
        logic [15:0] hold_limit;
        logic        accel_enable;
        logic [14:0] accel_rate;
        logic [14:0] accel_max;
        logic [14:0] decel_rate;
    } t_cfg;

    // One input item.
    typedef struct packed {
        logic [1:0] cmd;
        logic       pin_left;
        logic       pin_right;
        logic       pin_button;
    } t_item;

    // One result item plus its presence flag.
    typedef struct packed {
        logic             valid;
        logic signed [7:0] step_value;
        logic [1:0]       button_state;
    } t_result;

endpackage

>>> design/rebi_if.sv
// ----------------------------------------------------------------------------
// Rotary encoder button interface - channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface rebi_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       pin_left;
    logic       pin_right;
    logic       pin_button;

    modport source (output valid, output cmd, output pin_left, output pin_right,
                    output pin_button, input ready);
    modport sink   (input valid, input cmd, input pin_left, input pin_right,
                    input pin_button, output ready);
endinterface

// Result item channel.
interface rebi_result_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] step_value;
    logic [1:0]        button_state;

    modport source (output valid, output step_value, output button_state, input ready);
    modport sink   (input valid, input step_value, input button_state, output ready);
endinterface

// Register write channel.
interface rebi_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rebi_pkg::CFG_ADDR_W-1:0]     addr;
    logic [rebi_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> design/rebi_cfg_regs.sv
// ----------------------------------------------------------------------------
// Rotary encoder button interface - configuration registers
// Holds the eight control registers written through the register channel.
// ----------------------------------------------------------------------------
module rebi_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [rebi_pkg::CFG_ADDR_W-1:0] i_addr,
    input  logic [rebi_pkg::CFG_DATA_W-1:0] i_data,
    output rebi_pkg::t_cfg                  o_cfg
);

    rebi_pkg::t_cfg r_cfg;
    rebi_pkg::t_cfg n_cfg;

    // Decode one write beat into the register set.
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_addr)
                rebi_pkg::REG_ACTIVE_LEVEL:    n_cfg.active_level    = i_data[0];
                rebi_pkg::REG_BUTTON_ENABLE:   n_cfg.button_enable   = i_data[0];
                rebi_pkg::REG_BUTTON_INTERVAL: n_cfg.button_interval = i_data[15:0];
                rebi_pkg::REG_HOLD_LIMIT:      n_cfg.hold_limit      = i_data[15:0];
                rebi_pkg::REG_ACCEL_ENABLE:    n_cfg.accel_enable    = i_data[0];
                rebi_pkg::REG_ACCEL_RATE:      n_cfg.accel_rate      = i_data[14:0];
                rebi_pkg::REG_ACCEL_MAX:       n_cfg.accel_max       = i_data[14:0];
                rebi_pkg::REG_DECEL_RATE:      n_cfg.decel_rate      = i_data[14:0];
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level    <= 1'b0;
            r_cfg.button_enable   <= 1'b1;
            r_cfg.button_interval <= 16'd10;
            r_cfg.hold_limit      <= 16'd50;
            r_cfg.accel_enable    <= 1'b0;
            r_cfg.accel_rate      <= '0;
            r_cfg.accel_max       <= '0;
            r_cfg.decel_rate      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/rebi_engine.sv
// ----------------------------------------------------------------------------
// Rotary encoder button interface - processing engine
// Encoder and button state, updated once per item, and the read results.
// ----------------------------------------------------------------------------
module rebi_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  rebi_pkg::t_item  i_item,
    input  rebi_pkg::t_cfg   i_cfg,
    output rebi_pkg::t_result o_result
);

    rebi_pkg::t_arm    r_arm,      n_arm;
    logic signed [1:0] r_pending,  n_pending;
    logic [15:0]       r_accel,    n_accel;
    rebi_pkg::t_btn    r_btn,      n_btn;
    logic [15:0]       r_hold,     n_hold;
    logic [15:0]       r_interval, n_interval;

    logic              w_l_act, w_r_act, w_b_act;
    logic [15:0]       w_decay_diff;
    logic [15:0]       w_decayed;
    logic signed [17:0] w_grow_limit;
    logic              w_grow_ok;
    logic [15:0]       w_grown;
    logic              w_step_seen;
    logic [15:0]       w_interval_inc;
    logic [15:0]       w_hold_inc;
    logic [8:0]        w_mag;
    logic signed [7:0] w_step_out;

    // Pin activity against the configured active level.
    assign w_l_act = (i_item.pin_left   == i_cfg.active_level);
    assign w_r_act = (i_item.pin_right  == i_cfg.active_level);
    assign w_b_act = (i_item.pin_button == i_cfg.active_level);

    // Per-tick decay, clamped at zero when the result goes negative.
    assign w_decay_diff = r_accel - {1'b0, i_cfg.decel_rate};
    always_comb begin
        w_decayed = r_accel;
        if (i_cfg.accel_enable) begin
            w_decayed = w_decay_diff[15] ? 16'd0 : w_decay_diff;
        end
    end

    // Growth is allowed only while the level stays at or below max - rate.
    assign w_grow_limit = $signed({3'b000, i_cfg.accel_max})
                        - $signed({3'b000, i_cfg.accel_rate});
    assign w_grow_ok    = i_cfg.accel_enable
                        && ($signed({2'b00, w_decayed}) <= w_grow_limit);
    assign w_grown      = w_decayed + {1'b0, i_cfg.accel_rate};

    // Saturating increments.
    assign w_interval_inc = (r_interval < rebi_pkg::CNT_MAX) ? r_interval + 16'd1
                                                              : r_interval;
    assign w_hold_inc     = ((r_btn != rebi_pkg::BTN_HELD) && (r_hold < rebi_pkg::CNT_MAX))
                          ? r_hold + 16'd1 : r_hold;

    // Next-state logic for one accepted item.
    always_comb begin
        n_arm       = r_arm;
        n_pending   = r_pending;
        n_accel     = r_accel;
        n_btn       = r_btn;
        n_hold      = r_hold;
        n_interval  = r_interval;
        w_step_seen = 1'b0;
        if (i_fire) begin
            case (i_item.cmd)
                rebi_pkg::CMD_TICK: begin
                    n_accel = w_decayed;
                    // Arm on the first active pin, confirm when it goes inactive.
                    case (r_arm)
                        rebi_pkg::ARM_LEFT: begin
                            if (!w_l_act) begin
                                n_pending   = -2'sd1;
                                n_arm       = rebi_pkg::ARM_IDLE;
                                w_step_seen = 1'b1;
                            end
                        end
                        rebi_pkg::ARM_RIGHT: begin
                            if (!w_r_act) begin
                                n_pending   = 2'sd1;
                                n_arm       = rebi_pkg::ARM_IDLE;
                                w_step_seen = 1'b1;
                            end
                        end
                        default: begin
                            if (w_r_act) begin
                                n_arm = rebi_pkg::ARM_RIGHT;
                            end else if (w_l_act) begin
                                n_arm = rebi_pkg::ARM_LEFT;
                            end
                        end
                    endcase
                    if (w_step_seen && w_grow_ok) begin
                        n_accel = w_grown;
                    end
                    // Button check once per interval.
                    n_interval = w_interval_inc;
                    if (i_cfg.button_enable && (w_interval_inc >= i_cfg.button_interval)) begin
                        n_interval = 16'd0;
                        if (w_b_act) begin
                            n_hold = w_hold_inc;
                            if (w_hold_inc > i_cfg.hold_limit) begin
                                n_btn = rebi_pkg::BTN_HELD;
                            end
                        end else if (r_hold != 16'd0) begin
                            n_btn  = (r_btn == rebi_pkg::BTN_HELD) ? rebi_pkg::BTN_RELEASED
                                                                   : rebi_pkg::BTN_CLICKED;
                            n_hold = 16'd0;
                        end
                    end
                end
                rebi_pkg::CMD_READ_VALUE: begin
                    n_pending = 2'sd0;
                end
                rebi_pkg::CMD_READ_BUTTON: begin
                    if (r_btn != rebi_pkg::BTN_HELD) begin
                        n_btn = rebi_pkg::BTN_OPEN;
                    end
                end
                default: begin
                    n_arm = r_arm;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm      <= rebi_pkg::ARM_IDLE;
            r_pending  <= 2'sd0;
            r_accel    <= '0;
            r_btn      <= rebi_pkg::BTN_OPEN;
            r_hold     <= '0;
            r_interval <= '0;
        end else begin
            r_arm      <= n_arm;
            r_pending  <= n_pending;
            r_accel    <= n_accel;
            r_btn      <= n_btn;
            r_hold     <= n_hold;
            r_interval <= n_interval;
        end
    end

    // Step magnitude widened by the upper byte of the acceleration level.
    assign w_mag = i_cfg.accel_enable ? {1'b0, r_accel[15:8]} + 9'd1 : 9'd1;
    always_comb begin
        if (r_pending > 2'sd0) begin
            w_step_out = (w_mag > rebi_pkg::STEP_POS_LIMIT) ? 8'sd127 : $signed(w_mag[7:0]);
        end else if (r_pending < 2'sd0) begin
            w_step_out = (w_mag > rebi_pkg::STEP_NEG_LIMIT) ? -8'sd128
                                                            : $signed(~w_mag[7:0] + 8'd1);
        end else begin
            w_step_out = 8'sd0;
        end
    end

    // Result of the item now being processed.
    always_comb begin
        o_result.valid        = 1'b0;
        o_result.step_value   = 8'sd0;
        o_result.button_state = rebi_pkg::BTN_OPEN;
        case (i_item.cmd)
            rebi_pkg::CMD_READ_VALUE: begin
                o_result.valid      = 1'b1;
                o_result.step_value = w_step_out;
            end
            rebi_pkg::CMD_READ_BUTTON: begin
                o_result.valid        = 1'b1;
                o_result.button_state = r_btn;
            end
            default: begin
                o_result.valid = 1'b0;
            end
        endcase
    end

endmodule

>>> design/rotary_encoder_button_interface_unit.sv
// ----------------------------------------------------------------------------
// Rotary encoder button interface unit
// Decodes encoder detents with acceleration and debounces a push button.
// ----------------------------------------------------------------------------
//  Channel    Dir   Handshake      Payload
//  i_item     in    valid/ready    cmd, pin_left, pin_right, pin_button
//  o_result   out   valid/ready    step_value, button_state
//  i_cfg      in    valid/ready    addr (register index), data
//
//  Each item passes through the input register, and each read result through the
//  result register; one item is accepted per clock when the result side keeps up.
//  Tick beats make no result and never stall. A read beat stalls in the input
//  register only while an earlier result waits in the output register.
//  Reset is synchronous and active low; register writes are always ready.
// ----------------------------------------------------------------------------
module rotary_encoder_button_interface_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rebi_item_if.sink    i_item,
    rebi_result_if.source o_result,
    rebi_cfg_if.sink     i_cfg
);

    rebi_pkg::t_cfg    w_cfg;
    rebi_pkg::t_item   r_in_item;
    logic              r_in_valid;
    rebi_pkg::t_result w_res;
    logic              w_out_free;
    logic              w_advance;
    logic              r_out_valid;
    logic signed [7:0] r_out_step;
    logic [1:0]        r_out_button;

    // Register file.
    assign i_cfg.ready = 1'b1;

    rebi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_addr  (i_cfg.addr),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    // The item in the input register moves on unless its result has no room.
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_advance    = r_in_valid && (!w_res.valid || w_out_free);
    assign i_item.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_item.cmd        <= i_item.cmd;
            r_in_item.pin_left   <= i_item.pin_left;
            r_in_item.pin_right  <= i_item.pin_right;
            r_in_item.pin_button <= i_item.pin_button;
        end
    end

    rebi_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.valid) begin
            r_out_step   <= w_res.step_value;
            r_out_button <= w_res.button_state;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.step_value   = r_out_step;
    assign o_result.button_state = r_out_button;

    // No result is offered in the cycle after reset.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_result.valid)
        else $error("result offered right after reset");

    // A read beat that leaves the input register shows up as a result.
    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_item.cmd == rebi_pkg::CMD_READ_VALUE
                    || r_in_item.cmd == rebi_pkg::CMD_READ_BUTTON)) |=> r_out_valid)
        else $error("read beat lost its result");

    // A result carries either a step or a button state, never both.
    a_one_field_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.step_value == 8'sd0 || o_result.button_state == 2'd0))
        else $error("result carries both fields");

    // A tick beat never produces a result beat.
    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_item.cmd == rebi_pkg::CMD_TICK && !r_out_valid) |=> !r_out_valid)
        else $error("tick beat produced a result");

endmodule

>>> tb/encoder_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotary encoder button interface - scoreboard
// Tracks the detent machine, acceleration and button debounce state of the
// unit from the beats it accepts, and checks every readout it returns.
// ----------------------------------------------------------------------------
package encoder_check_pkg;
    import rebi_pkg::*;

    // One readout the unit owes the host.
    typedef struct {
        logic signed [7:0] step_value;
        t_btn              button_state;
    } t_readout;

    class encoder_scoreboard;
        // Shadow of the register set and of the unit's internal state.
        t_cfg        regs;
        t_arm        arm;
        int          step_dir;
        logic [15:0] accel;
        t_btn        btn;
        logic [15:0] hold_cnt;
        logic [15:0] interval_cnt;

        // Readouts predicted for read beats, oldest first.
        t_readout    readouts_due[$];

        int unsigned errors;
        int unsigned ticks;
        int unsigned value_reads;
        int unsigned button_reads;
        int unsigned undefined_cmds;
        int unsigned steps_reported;
        int unsigned clicks_reported;
        int unsigned holds_reported;
        int unsigned releases_reported;
        int unsigned result_beats;

        function new();
            regs.active_level    = 1'b0;
            regs.button_enable   = 1'b1;
            regs.button_interval = 16'd10;
            regs.hold_limit      = 16'd50;
            regs.accel_enable    = 1'b0;
            regs.accel_rate      = '0;
            regs.accel_max       = '0;
            regs.decel_rate      = '0;
            arm          = ARM_IDLE;
            step_dir     = 0;
            accel        = '0;
            btn          = BTN_OPEN;
            hold_cnt     = '0;
            interval_cnt = '0;
            errors       = 0;
        endfunction

        // Register write as seen on the configuration channel.
        function void write_register(logic [CFG_ADDR_W-1:0] addr,
                                     logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_ACTIVE_LEVEL:    regs.active_level    = data[0];
                REG_BUTTON_ENABLE:   regs.button_enable   = data[0];
                REG_BUTTON_INTERVAL: regs.button_interval = data;
                REG_HOLD_LIMIT:      regs.hold_limit      = data;
                REG_ACCEL_ENABLE:    regs.accel_enable    = data[0];
                REG_ACCEL_RATE:      regs.accel_rate      = data[14:0];
                REG_ACCEL_MAX:       regs.accel_max       = data[14:0];
                REG_DECEL_RATE:      regs.decel_rate      = data[14:0];
                default:             ;
            endcase
        endfunction

        // A detected detent adds acceleration only while the sum stays at or below the
        // ceiling; the compare is signed, so a rate above the ceiling never adds.
        function void boost_accel();
            int room;
            if (!regs.accel_enable) return;
            room = int'(regs.accel_max) - int'(regs.accel_rate);
            if (int'(accel) <= room)
                accel = accel + {1'b0, regs.accel_rate};
        endfunction

        // Advance the shadow state by one accepted input beat.
        function void note_item(logic [1:0] cmd, logic pin_l, logic pin_r, logic pin_b);
            t_readout due;
            logic     l_act;
            logic     r_act;
            logic     b_act;
            int       v;
            case (cmd)
                CMD_TICK: begin
                    ticks++;
                    l_act = (pin_l == regs.active_level);
                    r_act = (pin_r == regs.active_level);
                    b_act = (pin_b == regs.active_level);

                    // Acceleration decays first and clamps at zero.
                    if (regs.accel_enable) begin
                        accel = accel - {1'b0, regs.decel_rate};
                        if (accel[15]) accel = '0;
                    end

                    // Arm on an active pin, confirm the step when it drops.
                    case (arm)
                        ARM_LEFT: begin
                            if (!l_act) begin
                                step_dir = -1;
                                arm      = ARM_IDLE;
                                boost_accel();
                            end
                        end
                        ARM_RIGHT: begin
                            if (!r_act) begin
                                step_dir = 1;
                                arm      = ARM_IDLE;
                                boost_accel();
                            end
                        end
                        default: begin
                            if (l_act) arm = ARM_LEFT;
                            if (r_act) arm = ARM_RIGHT;
                        end
                    endcase

                    // Button is sampled once per interval.
                    if (interval_cnt != CNT_MAX) interval_cnt++;
                    if (regs.button_enable && interval_cnt >= regs.button_interval) begin
                        interval_cnt = '0;
                        if (b_act) begin
                            if (btn != BTN_HELD && hold_cnt != CNT_MAX) hold_cnt++;
                            if (hold_cnt > regs.hold_limit) btn = BTN_HELD;
                        end else if (hold_cnt != '0) begin
                            if (btn == BTN_HELD) btn = BTN_RELEASED;
                            else btn = BTN_CLICKED;
                            hold_cnt = '0;
                        end
                    end
                end
                CMD_READ_VALUE: begin
                    value_reads++;
                    v        = step_dir;
                    step_dir = 0;
                    if (regs.accel_enable) begin
                        if (v > 0) v = v + int'(accel[15:8]);
                        else if (v < 0) v = v - int'(accel[15:8]);
                    end
                    if (v > 127) v = 127;
                    if (v < -128) v = -128;
                    if (v != 0) steps_reported++;
                    due.step_value   = 8'(v);
                    due.button_state = BTN_OPEN;
                    readouts_due.push_back(due);
                end
                CMD_READ_BUTTON: begin
                    button_reads++;
                    case (btn)
                        BTN_CLICKED:  clicks_reported++;
                        BTN_HELD:     holds_reported++;
                        BTN_RELEASED: releases_reported++;
                        default: ;
                    endcase
                    due.step_value   = '0;
                    due.button_state = btn;
                    if (btn != BTN_HELD) btn = BTN_OPEN;
                    readouts_due.push_back(due);
                end
                default: undefined_cmds++;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("ERROR: %s", msg);
        endtask

        // Compare one result beat against the oldest readout owed.
        task check_result(logic signed [7:0] step_value, logic [1:0] button_state);
            t_readout due;
            result_beats++;
            if (readouts_due.size() == 0) begin
                report_mismatch($sformatf("result beat %0d with no read pending (step %0d, button %0d)",
                                          result_beats, step_value, button_state));
                return;
            end
            due = readouts_due.pop_front();
            if (step_value !== due.step_value)
                report_mismatch($sformatf("result beat %0d: step_value %0d, expected %0d",
                                          result_beats, step_value, due.step_value));
            if (button_state !== due.button_state)
                report_mismatch($sformatf("result beat %0d: button_state %0d, expected %0d",
                                          result_beats, button_state, due.button_state));
        endtask

        function int outstanding();
            return readouts_due.size();
        endfunction

        // Anything still owed at the end of the run never came out.
        task close_out();
            if (readouts_due.size() != 0)
                report_mismatch($sformatf("%0d readouts never returned", readouts_due.size()));
        endtask
    endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotary encoder button interface - testbench
// Drives tick and read beats with bursty timing against a stalling result
// side, steps through several register settings and checks every readout
// against a scoreboard that tracks the encoder, acceleration and button.
// ----------------------------------------------------------------------------
module testbench;
    import rebi_pkg::*;
    import encoder_check_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 105;
    localparam int RANDOM_PHASES   = 9;
    localparam int TIMEOUT_CYCLES  = 300_000;

    // Command code that the unit must ignore.
    localparam logic [1:0] CMD_UNDEFINED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rebi_item_if   item_ch ();
    rebi_result_if result_ch ();
    rebi_cfg_if    cfg_ch ();

    rotary_encoder_button_interface_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    encoder_scoreboard board = new();

    t_cfg        cur_settings;
    int unsigned settings_used;
    bit          hold_off_request;
    int unsigned hold_offs_done;

    // Encoder and button gesture state used to shape tick beats.
    bit turn_left;
    bit turn_right;
    bit pressed;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Observe every accepted beat on the three channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready)
                board.check_result(result_ch.step_value, result_ch.button_state);
            if (cfg_ch.valid && cfg_ch.ready)
                board.write_register(cfg_ch.addr, cfg_ch.data);
            if (item_ch.valid && item_ch.ready)
                board.note_item(item_ch.cmd, item_ch.pin_left, item_ch.pin_right,
                                item_ch.pin_button);
        end
    end

    // Result side: random stall patterns, plus a long hold-off on request.
    initial begin
        int          mode;
        int          span;
        int unsigned cyc;
        mode = 0;
        span = 0;
        cyc  = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_off_request) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
                hold_off_request = 1'b0;
                hold_offs_done++;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(8, 80);
                end
                span--;
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= ((cyc % 6) < 2);
                endcase
            end
        end
    end

    // Run limit.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("ERROR: run did not finish within %0d cycles", TIMEOUT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_item make_item(logic [1:0] cmd, logic l, logic r, logic b);
        t_item it;
        it.cmd        = cmd;
        it.pin_left   = l;
        it.pin_right  = r;
        it.pin_button = b;
        return it;
    endfunction

    // Offer one beat and hold it until accepted; valid stays high afterwards.
    task automatic send_item(input t_item it);
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= it.cmd;
        item_ch.pin_left   <= it.pin_left;
        item_ch.pin_right  <= it.pin_right;
        item_ch.pin_button <= it.pin_button;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
    endtask

    task automatic pause_items(input int cycles);
        item_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Wait until every readout is back and the input side has drained.
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    // Write the whole register set; unused upper bits carry junk.
    task automatic apply_settings(input t_cfg s);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_ACTIVE_LEVEL,    {junk[15:1], s.active_level});
        write_reg(REG_BUTTON_ENABLE,   {junk[14:0], s.button_enable});
        write_reg(REG_BUTTON_INTERVAL, s.button_interval);
        write_reg(REG_HOLD_LIMIT,      s.hold_limit);
        write_reg(REG_ACCEL_ENABLE,    {~junk[15:1], s.accel_enable});
        write_reg(REG_ACCEL_RATE,      {junk[0], s.accel_rate});
        write_reg(REG_ACCEL_MAX,       {junk[1], s.accel_max});
        write_reg(REG_DECEL_RATE,      {junk[2], s.decel_rate});
        cfg_ch.valid <= 1'b0;
        cur_settings = s;
        settings_used++;
    endtask

    // The first phases hit the register extremes, the rest are random.
    function automatic t_cfg pick_settings(input int phase);
        t_cfg s;
        case (phase)
            0: begin
                s = '{active_level: 1'b1, button_enable: 1'b1, button_interval: 16'd1,
                      hold_limit: 16'd0, accel_enable: 1'b1, accel_rate: 15'h7FFF,
                      accel_max: 15'h7FFF, decel_rate: 15'h7FFF};
            end
            1: begin
                s = '{active_level: 1'b0, button_enable: 1'b1, button_interval: 16'd0,
                      hold_limit: 16'hFFFF, accel_enable: 1'b1, accel_rate: 15'd0,
                      accel_max: 15'd0, decel_rate: 15'd0};
            end
            2: begin
                s = '{active_level: 1'b1, button_enable: 1'b0, button_interval: 16'hFFFF,
                      hold_limit: 16'hFFFF, accel_enable: 1'b0, accel_rate: 15'h7FFF,
                      accel_max: 15'd0, decel_rate: 15'h7FFF};
            end
            default: begin
                s.active_level  = 1'($urandom_range(0, 1));
                s.button_enable = ($urandom_range(0, 7) != 0);
                case ($urandom_range(0, 4))
                    0:       s.button_interval = 16'd0;
                    1:       s.button_interval = 16'd1;
                    default: s.button_interval = 16'($urandom_range(1, 4));
                endcase
                if ($urandom_range(0, 9) == 0) s.hold_limit = 16'hFFFF;
                else s.hold_limit = 16'($urandom_range(0, 5));
                s.accel_enable = ($urandom_range(0, 3) != 0);
                s.accel_rate   = 15'($urandom_range(64, 4000));
                s.accel_max    = 15'($urandom_range(4000, 32767));
                s.decel_rate   = 15'($urandom_range(0, 120));
                // Now and then a rate above the ceiling, which never adds.
                if ($urandom_range(0, 5) == 0) s.accel_max = 15'($urandom_range(0, 63));
            end
        endcase
        return s;
    endfunction

    // Mostly turn and press gestures, with some noise and reads mixed in.
    task automatic next_random_item(output t_item it);
        int   pick;
        logic act;
        act  = cur_settings.active_level;
        pick = $urandom_range(0, 99);
        it   = make_item(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        if (pick < 12) begin
            it.cmd = CMD_READ_VALUE;
        end else if (pick < 24) begin
            it.cmd = CMD_READ_BUTTON;
        end else if (pick < 28) begin
            it.cmd = CMD_UNDEFINED;
        end else if (pick >= 36) begin
            if (!turn_left && !turn_right) begin
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    turn_left = 1'b1;
                        2, 3:    turn_right = 1'b1;
                        default: begin
                            turn_left  = 1'b1;
                            turn_right = 1'b1;
                        end
                    endcase
                end
            end else if ($urandom_range(0, 1) == 0) begin
                turn_left  = 1'b0;
                turn_right = 1'b0;
            end
            if ($urandom_range(0, 15) == 0) pressed = !pressed;
            it.pin_left   = turn_left ? act : ~act;
            it.pin_right  = turn_right ? act : ~act;
            it.pin_button = pressed ? act : ~act;
        end
    endtask

    // Random beats in bursts of random length with random gaps between them.
    task automatic run_random(input int count);
        t_item it;
        int    sent;
        int    burst_left;
        int    gap;
        sent       = 0;
        burst_left = 0;
        while (sent < count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) pause_items(gap);
            end
            next_random_item(it);
            send_item(it);
            burst_left--;
            if (it.cmd != CMD_UNDEFINED) sent++;
        end
    endtask

    // Main sequence.
    initial begin
        t_cfg  s;
        t_item directed_reset[$];
        t_item directed_edge[$];
        item_ch.valid      <= 1'b0;
        item_ch.cmd        <= CMD_TICK;
        item_ch.pin_left   <= 1'b0;
        item_ch.pin_right  <= 1'b0;
        item_ch.pin_button <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.addr        <= REG_ACTIVE_LEVEL;
        cfg_ch.data        <= '0;
        i_rst_n            <= 1'b0;
        cur_settings = board.regs;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults, pins active low: empty reads, an ignored command,
        // a left detent and a detent with both pins active where right wins.
        directed_reset = '{
            make_item(CMD_READ_VALUE, 1'b1, 1'b1, 1'b1),
            make_item(CMD_READ_BUTTON, 1'b1, 1'b1, 1'b1),
            make_item(CMD_UNDEFINED, 1'b0, 1'b0, 1'b0),
            make_item(CMD_TICK, 1'b0, 1'b1, 1'b1),
            make_item(CMD_TICK, 1'b1, 1'b1, 1'b1),
            make_item(CMD_READ_VALUE, 1'b0, 1'b0, 1'b0),
            make_item(CMD_TICK, 1'b0, 1'b0, 1'b1),
            make_item(CMD_TICK, 1'b1, 1'b1, 1'b1),
            make_item(CMD_READ_VALUE, 1'b1, 1'b1, 1'b1)
        };
        foreach (directed_reset[i]) send_item(directed_reset[i]);
        settle();

        // Pins active high, full acceleration: step magnitude saturates both
        // ways, and a press sampled every tick goes held then released.
        s = '{active_level: 1'b1, button_enable: 1'b1, button_interval: 16'd1,
              hold_limit: 16'd0, accel_enable: 1'b1, accel_rate: 15'h7FFF,
              accel_max: 15'h7FFF, decel_rate: 15'd0};
        apply_settings(s);
        directed_edge = '{
            make_item(CMD_TICK, 1'b1, 1'b0, 1'b1),
            make_item(CMD_TICK, 1'b0, 1'b0, 1'b1),
            make_item(CMD_READ_VALUE, 1'b0, 1'b0, 1'b1),
            make_item(CMD_TICK, 1'b0, 1'b1, 1'b1),
            make_item(CMD_TICK, 1'b0, 1'b0, 1'b1),
            make_item(CMD_READ_VALUE, 1'b0, 1'b0, 1'b1),
            make_item(CMD_READ_BUTTON, 1'b0, 1'b0, 1'b1),
            make_item(CMD_READ_BUTTON, 1'b0, 1'b0, 1'b1),
            make_item(CMD_TICK, 1'b0, 1'b0, 1'b0),
            make_item(CMD_READ_BUTTON, 1'b0, 1'b0, 1'b0),
            make_item(CMD_READ_BUTTON, 1'b0, 1'b0, 1'b0)
        };
        foreach (directed_edge[i]) send_item(directed_edge[i]);
        settle();

        // Random phases; two of them start with a long result hold-off so
        // the unit backs up and stalls its input.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            apply_settings(pick_settings(phase));
            if (phase == 3 || phase == 6) hold_off_request = 1'b1;
            run_random(PHASE_ITEMS);
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        board.close_out();
        $display("Covered %0d ticks, %0d value reads (%0d nonzero steps), %0d button reads",
                 board.ticks, board.value_reads, board.steps_reported, board.button_reads);
        $display("Button reports: %0d clicked, %0d held, %0d released; %0d settings, %0d hold-offs",
                 board.clicks_reported, board.holds_reported, board.releases_reported,
                 settings_used, hold_offs_done);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
